// ----- src/ed1p_pkg.sv -----
// Shared types, constants and helpers of the 1-bit error-diffusion packer.
package ed1p_pkg;

    // Default size limits
    localparam int ED_MAX_WIDTH  = 1024;
    localparam int ED_MAX_HEIGHT = 1024;

    // Field and register widths
    localparam int PIXEL_W    = 8;
    localparam int BYTE_COL_W = 7;
    localparam int BMP_ROW_W  = 10;
    localparam int ERR_W      = 9;
    localparam int SUM_W      = 12;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_TDATA_W = 32;

    // Register reset values
    localparam logic [7:0]            EXPOSURE_RST = 8'd128;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RST    = 11'd128;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST   = 11'd64;

    // Arithmetic constants
    localparam logic signed [SUM_W-1:0] BIAS_MID     = 12'sd128;
    localparam logic signed [SUM_W-1:0] LEVEL_WHITE  = 12'sd255;
    localparam logic signed [SUM_W-1:0] WEIGHT_RIGHT = 12'sd7;
    localparam logic signed [SUM_W-1:0] WEIGHT_BL    = 12'sd3;
    localparam logic signed [SUM_W-1:0] WEIGHT_BELOW = 12'sd5;
    localparam int                      WEIGHT_SHIFT = 4;
    localparam logic signed [SUM_W-1:0] SHIFT_ROUND  = 12'sd15;
    localparam logic [7:0]              BIT_MSB      = 8'h80;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPOSURE = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic [7:0]            exposure;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } t_cfg;

    // Position flags of one pixel
    typedef struct packed {
        logic       first_row;
        logic       last_col;
        logic       last_row;
        logic       x_zero;
        logic [2:0] x_low;
    } t_pos;

    // Line store write requests of one pixel
    typedef struct packed {
        logic                    a_en;
        logic signed [ERR_W-1:0] a_data;
        logic                    b_en;
        logic signed [ERR_W-1:0] b_data;
    } t_store_wr;

    // Divide by 16 with truncation toward zero
    function automatic logic signed [SUM_W-1:0] div16_tz(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] adj;
        adj = (v < 0) ? (v + SHIFT_ROUND) : v;
        return adj >>> WEIGHT_SHIFT;
    endfunction

endpackage

// ----- src/error_diffusion_1bit_packer_unit.sv -----
// A pixel passes the input stage, then the output register that drives tvalid.
// Throughput: one pixel per cycle while the output accepts; the line store reads and
// writes one entry a cycle; a row-end second write goes out in the following cycle.
// Reset: synchronous, active low; clears counters, carries and valid flags.
// The line store needs no clearing pass: the first row of a frame reads zero.
module error_diffusion_1bit_packer_unit
    import ed1p_pkg::*;
#(
    parameter int MAX_WIDTH  = ED_MAX_WIDTH,
    parameter int MAX_HEIGHT = ED_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,  // [7:0] pixel
    // Packed byte stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] packed_byte, [14:8] byte_col,
                                                  // [24:15] bmp_row, [31:25] zero
    output logic                   m_axis_tlast   // frame_done
);

    localparam int XW = $clog2(MAX_WIDTH);

    t_cfg                    s_cfg;
    logic [XW-1:0]           s_x;
    t_pos                    s_pos;
    logic [BYTE_COL_W-1:0]   s_byte_col;
    logic [BMP_ROW_W-1:0]    s_bmp_row;
    logic                    s_accept;
    logic                    s_fire;

    // Input stage
    logic                    r_in_v;
    logic [PIXEL_W-1:0]      r_in_pixel;
    logic [XW-1:0]           r_in_x;
    t_pos                    r_in_pos;
    logic [BYTE_COL_W-1:0]   r_in_col;
    logic [BMP_ROW_W-1:0]    r_in_row;

    // Line store access
    logic                    s_we;
    logic [XW-1:0]           s_waddr;
    logic [ERR_W-1:0]        s_wdata;
    logic [ERR_W-1:0]        s_rdata;
    logic                    r_fwd_hit;
    logic [ERR_W-1:0]        r_fwd_data;
    logic                    r_pend_v;
    logic [XW-1:0]           r_pend_addr;
    logic [ERR_W-1:0]        r_pend_data;
    logic signed [ERR_W-1:0] s_below;

    // Core results
    t_store_wr               s_wr;
    logic                    s_emit;
    logic [7:0]              s_byte;

    // Output stage
    logic                    r_o_v;
    logic [7:0]              r_o_byte;
    logic [BYTE_COL_W-1:0]   r_o_col;
    logic [BMP_ROW_W-1:0]    r_o_row;
    logic                    r_o_done;

    assign o_cfg_ready = 1'b1;

    ed1p_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (s_cfg)
    );

    ed1p_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (s_accept),
        .i_width    (s_cfg.width),
        .i_height   (s_cfg.height),
        .o_x        (s_x),
        .o_pos      (s_pos),
        .o_byte_col (s_byte_col),
        .o_bmp_row  (s_bmp_row)
    );

    // Handshake: the item in the input stage moves on unless its byte is blocked
    assign s_fire        = r_in_v && (!s_emit || !r_o_v || m_axis_tready);
    assign s_axis_tready = !r_in_v || s_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Capture the accepted item and its position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_accept) begin
            r_in_v <= 1'b1;
        end else if (s_fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_pixel <= s_axis_tdata;
            r_in_x     <= s_x;
            r_in_pos   <= s_pos;
            r_in_col   <= s_byte_col;
            r_in_row   <= s_bmp_row;
        end
    end

    // Store write port: pending row-end write first, else the current item's write
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_pend_addr;
        s_wdata = r_pend_data;
        if (r_pend_v) begin
            s_we = 1'b1;
        end else if (s_fire && s_wr.a_en) begin
            s_we    = 1'b1;
            s_waddr = r_in_x - XW'(1);
            s_wdata = s_wr.a_data;
        end else if (s_fire && s_wr.b_en) begin
            s_we    = 1'b1;
            s_waddr = r_in_x;
            s_wdata = s_wr.b_data;
        end
    end

    // Hold the row-end write when both writes fall in one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= s_fire && s_wr.a_en && s_wr.b_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= r_in_x;
        r_pend_data <= s_wr.b_data;
    end

    ed1p_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_accept),
        .i_raddr (s_x),
        .o_rdata (s_rdata)
    );

    // Forward a write that lands on the read address at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (s_accept) begin
            r_fwd_hit <= s_we && (s_waddr == s_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_fwd_data <= s_wdata;
        end
    end

    assign s_below = r_in_pos.first_row ? '0
                   : $signed(r_fwd_hit ? r_fwd_data : s_rdata);

    ed1p_diffuse u_diffuse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s_fire),
        .i_pixel    (r_in_pixel),
        .i_exposure (s_cfg.exposure),
        .i_below    (s_below),
        .i_pos      (r_in_pos),
        .o_wr       (s_wr),
        .o_emit     (s_emit),
        .o_byte     (s_byte)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s_fire && s_emit) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_emit) begin
            r_o_byte <= s_byte;
            r_o_col  <= r_in_col;
            r_o_row  <= r_in_row;
            r_o_done <= r_in_pos.last_col && r_in_pos.last_row;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 8 - BYTE_COL_W - BMP_ROW_W){1'b0}},
                            r_o_row, r_o_col, r_o_byte};
    assign m_axis_tlast  = r_o_done;

    // A held row-end write never meets a write of the current item
    a_pend_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> !(s_fire && (s_wr.a_en || s_wr.b_en)))
        else $error("pending store write collides with a new write");

    // The last byte of a frame belongs to the bottom bitmap row
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[24:15] == '0))
        else $error("frame end on a nonzero bitmap row");

    // An accepted item sits in the input stage in the next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_in_v)
        else $error("accepted item lost from the input stage");

endmodule

// ----- src/ed1p_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ed1p_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ed1p_cfg.sv -----
// Configuration registers of the error-diffusion packer.
module ed1p_cfg
    import ed1p_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Decode register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exposure <= EXPOSURE_RST;
            r_cfg.width    <= WIDTH_RST;
            r_cfg.height   <= HEIGHT_RST;
        end else if (i_wr) begin
            case (i_index)
                CFG_EXPOSURE: r_cfg.exposure <= i_data[7:0];
                CFG_WIDTH:    r_cfg.width    <= i_data;
                CFG_HEIGHT:   r_cfg.height   <= i_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/ed1p_pos.sv -----
// Raster position counter: column, row and row/frame end flags of each pixel.
module ed1p_pos
    import ed1p_pkg::*;
#(
    parameter int MAX_WIDTH  = ED_MAX_WIDTH,
    parameter int MAX_HEIGHT = ED_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [CFG_DATA_W-1:0] i_width,
    input  logic [CFG_DATA_W-1:0] i_height,
    output logic [$clog2(MAX_WIDTH)-1:0] o_x,
    output t_pos                  o_pos,
    output logic [BYTE_COL_W-1:0] o_byte_col,
    output logic [BMP_ROW_W-1:0]  o_bmp_row
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [WW-1:0] s_effw;
    logic [HW-1:0] s_effh;
    logic          s_last_col;
    logic          s_last_row;

    // Clamp the frame size to 1..max
    always_comb begin
        if (i_width == '0) begin
            s_effw = WW'(1);
        end else if (32'(i_width) > 32'(MAX_WIDTH)) begin
            s_effw = WW'(MAX_WIDTH);
        end else begin
            s_effw = WW'(i_width);
        end
        if (i_height == '0) begin
            s_effh = HW'(1);
        end else if (32'(i_height) > 32'(MAX_HEIGHT)) begin
            s_effh = HW'(MAX_HEIGHT);
        end else begin
            s_effh = HW'(i_height);
        end
    end

    // Flags and output indexes of the current position
    always_comb begin
        s_last_col = (WW'(r_x) + WW'(1)) >= s_effw;
        s_last_row = (HW'(r_y) + HW'(1)) >= s_effh;
        o_pos.first_row = (r_y == '0);
        o_pos.last_col  = s_last_col;
        o_pos.last_row  = s_last_row;
        o_pos.x_zero    = (r_x == '0);
        o_pos.x_low     = r_x[2:0];
        o_byte_col      = BYTE_COL_W'(r_x >> 3);
        o_bmp_row       = (HW'(r_y) < s_effh) ? BMP_ROW_W'(s_effh - HW'(1) - HW'(r_y))
                                              : '0;
    end

    // Advance one pixel; wrap at row and frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_advance) begin
            if (s_last_col) begin
                r_x <= '0;
                r_y <= s_last_row ? '0 : (r_y + YW'(1));
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

    assign o_x = r_x;

endmodule

// ----- src/ed1p_diffuse.sv -----
// Threshold, error split and bit packing of one pixel, with the row carries.
module ed1p_diffuse
    import ed1p_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [PIXEL_W-1:0]      i_pixel,
    input  logic [7:0]              i_exposure,
    input  logic signed [ERR_W-1:0] i_below,
    input  t_pos                    i_pos,
    output t_store_wr               o_wr,
    output logic                    o_emit,
    output logic [7:0]              o_byte
);

    logic signed [ERR_W-1:0] r_right;
    logic signed [ERR_W-1:0] r_bl_part;
    logic signed [ERR_W-1:0] r_b_part;
    logic [7:0]              r_acc;

    logic signed [SUM_W-1:0] s_sum;
    logic [7:0]              s_clamp;
    logic                    s_white;
    logic signed [ERR_W-1:0] s_err;
    logic signed [ERR_W-1:0] s_e7;
    logic signed [ERR_W-1:0] s_e3;
    logic signed [ERR_W-1:0] s_e5;
    logic signed [ERR_W-1:0] s_e1;
    logic signed [ERR_W-1:0] n_bl_part;
    logic [7:0]              n_acc;

    // Bias, add carried errors, clamp and threshold
    always_comb begin
        s_sum = $signed({4'b0, i_pixel}) + (BIAS_MID - $signed({4'b0, i_exposure}))
              + SUM_W'(i_below) + SUM_W'(r_right);
        if (s_sum < 0) begin
            s_clamp = 8'd0;
        end else if (s_sum > LEVEL_WHITE) begin
            s_clamp = 8'd255;
        end else begin
            s_clamp = s_sum[7:0];
        end
        s_white = s_clamp[7];
        s_err = s_white ? ERR_W'($signed({4'b0, s_clamp}) - LEVEL_WHITE)
                        : $signed({1'b0, s_clamp});
    end

    // Split the error into its shares
    always_comb begin
        s_e7 = ERR_W'(div16_tz(SUM_W'(s_err) * WEIGHT_RIGHT));
        s_e3 = ERR_W'(div16_tz(SUM_W'(s_err) * WEIGHT_BL));
        s_e5 = ERR_W'(div16_tz(SUM_W'(s_err) * WEIGHT_BELOW));
        s_e1 = s_err - s_e7 - s_e3 - s_e5;
        n_bl_part = r_b_part + s_e5;
    end

    // Line store writes: finished left neighbor, and own column at row end
    always_comb begin
        o_wr.a_en   = !i_pos.x_zero;
        o_wr.a_data = r_bl_part + s_e3;
        o_wr.b_en   = i_pos.last_col;
        o_wr.b_data = n_bl_part;
    end

    // Pack the bit, MSB first
    always_comb begin
        n_acc  = r_acc | (s_white ? (BIT_MSB >> i_pos.x_low) : 8'd0);
        o_emit = (i_pos.x_low == 3'd7) || i_pos.last_col;
        o_byte = n_acc;
    end

    // Advance carries; clear them at row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right   <= '0;
            r_bl_part <= '0;
            r_b_part  <= '0;
            r_acc     <= '0;
        end else if (i_fire) begin
            if (i_pos.last_col) begin
                r_right   <= '0;
                r_bl_part <= '0;
                r_b_part  <= '0;
            end else begin
                r_right   <= s_e7;
                r_bl_part <= n_bl_part;
                r_b_part  <= s_e1;
            end
            r_acc <= o_emit ? 8'd0 : n_acc;
        end
    end

endmodule
